// ===== rtl/nfcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_pkg: shared types and constants of the NOR flash command sequencer
// Command codes that pass from the front to the back, result beat layout and
// the function that expands a command into its bus beats.
// ----------------------------------------------------------------------------
package nfcs_pkg;

	// Flash address width inside the block; the bus address port stays 20 bits.
	localparam int ADDRESS_BITS = 20;
	localparam int BUS_ADDR_W   = 20;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ADDRESS_BITS-1:0] addr_t;
	typedef logic [BUS_ADDR_W-1:0]   bus_addr_t;

	// Request types.
	localparam logic [2:0] REQ_RESET   = 3'd0;
	localparam logic [2:0] REQ_PROGRAM = 3'd1;
	localparam logic [2:0] REQ_ERASE   = 3'd2;
	localparam logic [2:0] REQ_READ_ID = 3'd3;
	localparam logic [2:0] REQ_RETURN  = 3'd4;
	localparam logic [2:0] REQ_TICK    = 3'd5;

	// Result operation kinds.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_DONE  = 2'd2;

	// Completion status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_PROG_FAIL  = 2'd1;
	localparam logic [1:0] ST_ERASE_FAIL = 2'd2;
	localparam logic [1:0] ST_BUSY       = 2'd3;

	// Command sequences handed from the front to the back.
	localparam logic [2:0] SEQ_ABORT   = 3'd0; // two reset writes, then completion
	localparam logic [2:0] SEQ_PROGRAM = 3'd1;
	localparam logic [2:0] SEQ_ERASE   = 3'd2;
	localparam logic [2:0] SEQ_READ_ID = 3'd3;
	localparam logic [2:0] SEQ_READ    = 3'd4;
	localparam logic [2:0] SEQ_DONE    = 3'd5;

	// Command bytes and unlock addresses.
	localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
	localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
	localparam logic [7:0] CMD_RESET   = 8'hF0;
	localparam logic [7:0] CMD_PROGRAM = 8'hA0;
	localparam logic [7:0] CMD_ERASE   = 8'h80;
	localparam logic [7:0] CMD_CHIP    = 8'h10;
	localparam logic [7:0] CMD_AUTOSEL = 8'h90;

	localparam addr_t ADDR_UNLOCK1 = addr_t'(12'h555);
	localparam addr_t ADDR_UNLOCK2 = addr_t'(12'hAAA);
	localparam addr_t ADDR_ZERO    = addr_t'(1'b0);
	localparam addr_t ADDR_TOGGLE  = addr_t'(1'b1);
	localparam addr_t ID_OFS_HIGH  = addr_t'(12'h100);
	localparam addr_t ID_OFS_LOW   = addr_t'(12'h101);

	localparam logic [15:0] PROG_TIMEOUT_RESET  = 16'd2;
	localparam logic [15:0] ERASE_TIMEOUT_RESET = 16'd2000;

	typedef struct packed {
		logic [2:0]  seq;
		addr_t       addr;
		logic [7:0]  data;
		logic [1:0]  status;
		logic [15:0] id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  op;
		bus_addr_t   addr;
		logic [7:0]  data;
		logic [1:0]  status;
		logic [15:0] id;
		logic        last;
	} beat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic beat_t mk_write(logic [7:0] data, addr_t a);
		beat_t b;
		b = '0;
		b.op = OP_WRITE;
		b.addr = bus_addr_t'(a);
		b.data = data;
		return b;
	endfunction

	function automatic beat_t mk_read(addr_t a);
		beat_t b;
		b = '0;
		b.op = OP_READ;
		b.addr = bus_addr_t'(a);
		b.last = 1'b1;
		return b;
	endfunction

	function automatic beat_t mk_done(logic [1:0] status, logic [15:0] id);
		beat_t b;
		b = '0;
		b.op = OP_DONE;
		b.status = status;
		b.id = id;
		b.last = 1'b1;
		return b;
	endfunction

	// Beat number idx of command c; the final beat of each sequence carries last.
	function automatic beat_t beat_of(cmd_t c, logic [3:0] idx);
		beat_t b;
		b = '0;
		case (c.seq)
			SEQ_ABORT: begin
				if (idx < 4'd2) b = mk_write(CMD_RESET, ADDR_ZERO);
				else            b = mk_done(c.status, c.id);
			end
			SEQ_PROGRAM: begin
				case (idx)
					4'd0:    b = mk_write(CMD_UNLOCK1, ADDR_UNLOCK1);
					4'd1:    b = mk_write(CMD_UNLOCK2, ADDR_UNLOCK2);
					4'd2:    b = mk_write(CMD_PROGRAM, ADDR_UNLOCK1);
					4'd3:    b = mk_write(c.data, c.addr);
					default: b = mk_read(c.addr);
				endcase
			end
			SEQ_ERASE: begin
				case (idx)
					4'd0, 4'd1: b = mk_write(CMD_RESET, ADDR_ZERO);
					4'd2:       b = mk_write(CMD_UNLOCK1, ADDR_UNLOCK1);
					4'd3:       b = mk_write(CMD_UNLOCK2, ADDR_UNLOCK2);
					4'd4:       b = mk_write(CMD_ERASE, ADDR_UNLOCK1);
					4'd5:       b = mk_write(CMD_UNLOCK1, ADDR_UNLOCK1);
					4'd6:       b = mk_write(CMD_UNLOCK2, ADDR_UNLOCK2);
					4'd7:       b = mk_write(CMD_CHIP, ADDR_UNLOCK1);
					default:    b = mk_read(ADDR_TOGGLE);
				endcase
			end
			SEQ_READ_ID: begin
				case (idx)
					4'd0, 4'd1: b = mk_write(CMD_RESET, ADDR_ZERO);
					4'd2:       b = mk_write(CMD_UNLOCK1, ADDR_UNLOCK1);
					4'd3:       b = mk_write(CMD_UNLOCK2, ADDR_UNLOCK2);
					4'd4:       b = mk_write(CMD_AUTOSEL, ADDR_UNLOCK1);
					default:    b = mk_read(c.addr);
				endcase
			end
			SEQ_READ: b = mk_read(c.addr);
			default:  b = mk_done(c.status, c.id);
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/nor_flash_command_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer: NOR flash command set controller
// Turns reset, program, erase and read ID requests into bus beats and polls
// the flash with read returns and ticks until completion.
// ----------------------------------------------------------------------------
// The first result beat of a request passes the command queue, the back
// sequencer's command register and its output register. Throughput: one
// result beat per cycle while out_ready holds; a request gives one to nine
// beats. The front takes a request every cycle while the four-entry queue has
// room. Reset clears the phase and the queue and sets the timeouts to 2 and 2000.
module nor_flash_command_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [19:0] address,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       op_kind,
	output logic [19:0]      bus_address,
	output logic [7:0]       bus_data,
	output logic [1:0]       status,
	output logic [15:0]      id_value,
	output logic             last
);
	import nfcs_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	beat_t   out_beat;

	assign cfg_ready = 1'b1;

	nfcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.address   (address),
		.data_byte (data_byte),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	nfcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	nfcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_beat  (out_beat)
	);

	// Result beat fields.
	assign op_kind     = out_beat.op;
	assign bus_address = 20'(out_beat.addr);
	assign bus_data    = out_beat.data;
	assign status      = out_beat.status;
	assign id_value    = out_beat.id;
	assign last        = out_beat.last;

endmodule
`default_nettype wire

// ===== rtl/nfcs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_front: request decode and polling state
// Accepts request beats, keeps the operation phase, tick count and timeout
// registers, and pushes one command per result-producing request.
// ----------------------------------------------------------------------------
module nfcs_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        req_type,
	input  wire logic [19:0]       address,
	input  wire logic [7:0]        data_byte,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire nfcs_pkg::q_stat_t q_stat,
	output logic                   push,
	output nfcs_pkg::cmd_t         push_cmd
);
	import nfcs_pkg::*;

	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_PROG_POLL   = 4'd1;
	localparam logic [3:0] PH_PROG_FINAL  = 4'd2;
	localparam logic [3:0] PH_PROG_VERIFY = 4'd3;
	localparam logic [3:0] PH_ER_FIRST    = 4'd4;
	localparam logic [3:0] PH_ER_POLL     = 4'd5;
	localparam logic [3:0] PH_ER_FINAL    = 4'd6;
	localparam logic [3:0] PH_ID_HIGH     = 4'd7;
	localparam logic [3:0] PH_ID_LOW      = 4'd8;

	logic [3:0]  phase_q, phase_d;
	addr_t       target_q, target_d;
	logic [7:0]  expected_q, expected_d;
	logic [7:0]  prev_toggle_q, prev_toggle_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [7:0]  id_high_q, id_high_d;
	logic [15:0] prog_to_q, erase_to_q;

	logic  accept;
	addr_t in_addr;
	logic  busy;
	logic  prog_match;
	logic  toggle_same;
	logic  dq5;

	assign in_ready    = !q_stat.full;
	assign accept      = in_valid && in_ready;
	assign in_addr     = addr_t'(address);
	assign busy        = (phase_q != PH_IDLE);
	assign prog_match  = !(data_byte[7] ^ expected_q[7]);
	assign toggle_same = !(data_byte[6] ^ prev_toggle_q[6]);
	assign dq5         = data_byte[5];

	// Decode of one request into the next state and an optional command.
	always_comb begin
		phase_d       = phase_q;
		target_d      = target_q;
		expected_d    = expected_q;
		prev_toggle_d = prev_toggle_q;
		elapsed_d     = elapsed_q;
		id_high_d     = id_high_q;
		push          = 1'b0;
		push_cmd      = '0;
		if (accept) begin
			case (req_type)
				REQ_RESET: begin
					push            = 1'b1;
					push_cmd.seq    = SEQ_ABORT;
					push_cmd.status = ST_OK;
					phase_d         = PH_IDLE;
				end
				REQ_PROGRAM, REQ_ERASE, REQ_READ_ID: begin
					push = 1'b1;
					if (busy) begin
						push_cmd.seq    = SEQ_DONE;
						push_cmd.status = ST_BUSY;
					end else begin
						elapsed_d = '0;
						if (req_type == REQ_PROGRAM) begin
							push_cmd.seq  = SEQ_PROGRAM;
							push_cmd.addr = in_addr;
							push_cmd.data = data_byte;
							target_d      = in_addr;
							expected_d    = data_byte;
							phase_d       = (prog_to_q != 16'd0) ? PH_PROG_POLL : PH_PROG_FINAL;
						end else if (req_type == REQ_ERASE) begin
							push_cmd.seq = SEQ_ERASE;
							phase_d      = PH_ER_FIRST;
						end else begin
							push_cmd.seq  = SEQ_READ_ID;
							push_cmd.addr = in_addr + ID_OFS_HIGH;
							target_d      = in_addr;
							phase_d       = PH_ID_HIGH;
						end
					end
				end
				REQ_RETURN: begin
					case (phase_q)
						PH_PROG_POLL, PH_PROG_FINAL: begin
							if (prog_match || phase_q == PH_PROG_POLL) begin
								push          = 1'b1;
								push_cmd.seq  = SEQ_READ;
								push_cmd.addr = target_q;
								if (prog_match) begin
									phase_d = PH_PROG_VERIFY;
								end else if (dq5 || elapsed_q >= prog_to_q) begin
									phase_d = PH_PROG_FINAL;
								end
							end else begin
								push            = 1'b1;
								push_cmd.seq    = SEQ_DONE;
								push_cmd.status = ST_PROG_FAIL;
								phase_d         = PH_IDLE;
							end
						end
						PH_PROG_VERIFY: begin
							push            = 1'b1;
							push_cmd.seq    = SEQ_DONE;
							push_cmd.status = (data_byte == expected_q) ? ST_OK : ST_PROG_FAIL;
							phase_d         = PH_IDLE;
						end
						PH_ER_FIRST: begin
							prev_toggle_d = data_byte;
							push          = 1'b1;
							push_cmd.seq  = SEQ_READ;
							push_cmd.addr = ADDR_TOGGLE;
							phase_d       = (elapsed_q < erase_to_q) ? PH_ER_POLL : PH_ER_FINAL;
						end
						PH_ER_POLL: begin
							push = 1'b1;
							if (toggle_same) begin
								push_cmd.seq    = SEQ_DONE;
								push_cmd.status = ST_OK;
								phase_d         = PH_IDLE;
							end else begin
								prev_toggle_d = data_byte;
								push_cmd.seq  = SEQ_READ;
								push_cmd.addr = ADDR_TOGGLE;
								if (dq5 || elapsed_q >= erase_to_q) begin
									phase_d = PH_ER_FINAL;
								end
							end
						end
						PH_ER_FINAL: begin
							push            = 1'b1;
							push_cmd.seq    = SEQ_DONE;
							push_cmd.status = toggle_same ? ST_OK : ST_ERASE_FAIL;
							phase_d         = PH_IDLE;
						end
						PH_ID_HIGH: begin
							id_high_d     = data_byte;
							push          = 1'b1;
							push_cmd.seq  = SEQ_READ;
							push_cmd.addr = target_q + ID_OFS_LOW;
							phase_d       = PH_ID_LOW;
						end
						PH_ID_LOW: begin
							push            = 1'b1;
							push_cmd.seq    = SEQ_ABORT;
							push_cmd.status = ST_OK;
							push_cmd.id     = {id_high_q, data_byte};
							phase_d         = PH_IDLE;
						end
						default: begin
						end
					endcase
				end
				REQ_TICK: begin
					if (busy && elapsed_q != 16'hFFFF) begin
						elapsed_d = elapsed_q + 16'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operation state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			target_q      <= '0;
			expected_q    <= '0;
			prev_toggle_q <= '0;
			elapsed_q     <= '0;
			id_high_q     <= '0;
		end else begin
			phase_q       <= phase_d;
			target_q      <= target_d;
			expected_q    <= expected_d;
			prev_toggle_q <= prev_toggle_d;
			elapsed_q     <= elapsed_d;
			id_high_q     <= id_high_d;
		end
	end

	// Timeout registers, written through the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_to_q  <= PROG_TIMEOUT_RESET;
			erase_to_q <= ERASE_TIMEOUT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index) erase_to_q <= cfg_data;
			else           prog_to_q  <= cfg_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/nfcs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_queue: command queue between front and back
// A small first-in first-out buffer of decoded commands.
// ----------------------------------------------------------------------------
module nfcs_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire nfcs_pkg::cmd_t    push_cmd,
	input  wire logic              pop,
	output nfcs_pkg::cmd_t         head,
	output nfcs_pkg::q_stat_t      q_stat
);
	import nfcs_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = entry_q[rd_ptr_q];

	// Entry storage; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/nfcs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcs_back: bus beat sequencer
// Takes commands from the queue and emits their bus writes, reads and completion
// reports one beat per cycle while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module nfcs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nfcs_pkg::cmd_t    head,
	input  wire nfcs_pkg::q_stat_t q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output nfcs_pkg::beat_t        out_beat
);
	import nfcs_pkg::*;

	cmd_t       cur_q;
	logic       active_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	beat_t      out_q;
	beat_t      beat;
	logic       out_free;
	logic       emit;

	assign beat      = beat_of(cur_q, idx_q);
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = active_q && out_free;
	assign pop       = !q_stat.empty && (!active_q || (emit && beat.last));
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	// Current command and beat counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (emit) begin
			if (beat.last) active_q <= 1'b0;
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= beat;
	end

	// No sequence is longer than nine beats.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= 4'd8))
		else $error("beat counter past the longest sequence");

	// A completion report always closes the results of its request.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.op == OP_DONE) |-> out_q.last)
		else $error("completion report without last");

	// A new command is taken only when the previous one has ended.
	a_pop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && active_q) |-> (emit && beat.last))
		else $error("command replaced before its final beat");

endmodule
`default_nettype wire
